>>> rtl/xor_checked_frame_parser_assert.svh
// ------------------------------------------------------------------------------------------
// assertion macros for the frame parser
// shared clock and reset wrappers for concurrent checks
// ------------------------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_PARSER_ASSERT_SVH
`define XOR_CHECKED_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XCFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define XCFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/xcfp_pkg.sv
// ------------------------------------------------------------------------------------------
// xcfp_pkg
// types and constants for the xor checked frame parser
// ------------------------------------------------------------------------------------------
package xcfp_pkg;

	localparam int PACKED_WORD_BITS_DEF = 32;
	localparam int BYTE_BITS            = 8;
	localparam int OUT_WORD_BITS        = 32;
	localparam int CNT_BITS             = 9;

	localparam logic [BYTE_BITS-1:0] IMAGE_MARKER_RST   = 8'hCC;
	localparam logic [BYTE_BITS-1:0] COMMAND_MARKER_RST = 8'hCD;

	typedef enum logic [0:0] {
		REG_IMAGE_MARKER   = 1'b0,
		REG_COMMAND_MARKER = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_CMD_OK  = 2'd0,
		ST_IMG_OK  = 2'd1,
		ST_SUM_ERR = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_CMD  = 5'b00010,
		PH_ADDR = 5'b00100,
		PH_DATA = 5'b01000,
		PH_SUM  = 5'b10000
	} phase_t;

endpackage

>>> rtl/xor_checked_frame_parser.sv
// ------------------------------------------------------------------------------------------
// xor checked frame parser
// length-prefixed frame parser with running xor checksum, while rx is not stalled one byte per cycle
// ------------------------------------------------------------------------------------------
// channel   direction  handshake             payload
// rx        in         rx_valid / rx_stall    rx_byte
// res       out        res_valid / res_stall  status, lengths, packed words
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one byte is taken per cycle while rx is not stalled; each byte updates the parse state in a single pass
// a result appears in the cycle after the checksum byte is accepted, held in the result register
// rx is stalled only while a result waits and res_stall is high
// arst_n clears parse state, result valid and restores the marker reset values
// cfg_ready is always high
// ------------------------------------------------------------------------------------------
module xor_checked_frame_parser #(
	parameter int PACKED_WORD_BITS = xcfp_pkg::PACKED_WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rx_valid,
	output logic                               rx_stall,
	input  logic [xcfp_pkg::BYTE_BITS-1:0]     rx_byte,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [1:0]                         status,
	output logic [xcfp_pkg::BYTE_BITS-1:0]     address_length,
	output logic [xcfp_pkg::OUT_WORD_BITS-1:0] address_word,
	output logic [xcfp_pkg::BYTE_BITS-1:0]     payload_length,
	output logic [xcfp_pkg::OUT_WORD_BITS-1:0] payload_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [0:0]                         cfg_index,
	input  logic [xcfp_pkg::BYTE_BITS-1:0]     cfg_data
);

	`include "xor_checked_frame_parser_assert.svh"

	xcfp_pkg::phase_t                   phase_q, phase_d;
	logic                               is_cmd_q, is_cmd_d;
	logic [xcfp_pkg::CNT_BITS-1:0]      cnt_q, cnt_d, cnt_inc;
	logic [xcfp_pkg::BYTE_BITS-1:0]     alen_q, alen_d, dlen_q, dlen_d;
	logic [PACKED_WORD_BITS-1:0]        aacc_q, aacc_d, dacc_q, dacc_d;
	logic [xcfp_pkg::BYTE_BITS-1:0]     xor_q, xor_d;
	logic [xcfp_pkg::BYTE_BITS-1:0]     img_mark_q, cmd_mark_q;
	logic                               rx_accept, sum_fire;

	logic                               res_valid_q;
	xcfp_pkg::status_t                  status_q, status_d;
	logic [xcfp_pkg::BYTE_BITS-1:0]     alen_out_q, alen_out_d, dlen_out_q, dlen_out_d;
	logic [xcfp_pkg::OUT_WORD_BITS-1:0] aword_q, aword_d, dword_q, dword_d;

	assign cfg_ready = 1'b1;
	assign rx_stall  = res_valid_q & res_stall;
	assign rx_accept = rx_valid & ~rx_stall;
	assign sum_fire  = rx_accept && (phase_q == xcfp_pkg::PH_SUM);
	assign cnt_inc   = cnt_q + xcfp_pkg::CNT_BITS'(1);

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_mark_q <= xcfp_pkg::IMAGE_MARKER_RST;
			cmd_mark_q <= xcfp_pkg::COMMAND_MARKER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (xcfp_pkg::reg_index_t'(cfg_index))
				xcfp_pkg::REG_IMAGE_MARKER:   img_mark_q <= cfg_data;
				xcfp_pkg::REG_COMMAND_MARKER: cmd_mark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parse step
	always_comb begin
		phase_d    = phase_q;
		is_cmd_d   = is_cmd_q;
		cnt_d      = cnt_q;
		alen_d     = alen_q;
		dlen_d     = dlen_q;
		aacc_d     = aacc_q;
		dacc_d     = dacc_q;
		xor_d      = xor_q;
		status_d   = xcfp_pkg::ST_SUM_ERR;
		alen_out_d = '0;
		aword_d    = '0;
		dlen_out_d = '0;
		dword_d    = '0;
		unique case (phase_q)
			xcfp_pkg::PH_CMD: begin
				xor_d   = xor_q ^ rx_byte;
				cnt_d   = '0;
				phase_d = xcfp_pkg::PH_ADDR;
			end
			xcfp_pkg::PH_ADDR: begin
				xor_d = xor_q ^ rx_byte;
				if (cnt_q == '0) begin
					alen_d = rx_byte;
					aacc_d = '0;
				end else begin
					aacc_d = PACKED_WORD_BITS'({aacc_q, rx_byte});
				end
				cnt_d = cnt_inc;
				if (cnt_inc == ({1'b0, alen_d} + xcfp_pkg::CNT_BITS'(1))) begin
					cnt_d   = '0;
					phase_d = xcfp_pkg::PH_DATA;
				end
			end
			xcfp_pkg::PH_DATA: begin
				xor_d = xor_q ^ rx_byte;
				if (cnt_q == '0) begin
					dlen_d = rx_byte;
					dacc_d = '0;
				end else begin
					dacc_d = PACKED_WORD_BITS'({dacc_q, rx_byte});
				end
				cnt_d = cnt_inc;
				if (cnt_inc == ({1'b0, dlen_d} + xcfp_pkg::CNT_BITS'(1))) begin
					cnt_d   = '0;
					phase_d = xcfp_pkg::PH_SUM;
				end
			end
			xcfp_pkg::PH_SUM: begin
				if (rx_byte == xor_q) begin
					if (is_cmd_q) begin
						status_d   = xcfp_pkg::ST_CMD_OK;
						alen_out_d = alen_q;
						aword_d    = xcfp_pkg::OUT_WORD_BITS'(aacc_q);
						dlen_out_d = dlen_q;
						dword_d    = xcfp_pkg::OUT_WORD_BITS'(dacc_q);
					end else begin
						status_d = xcfp_pkg::ST_IMG_OK;
					end
				end
				cnt_d   = '0;
				phase_d = xcfp_pkg::PH_HUNT;
			end
			default: begin
				phase_d = xcfp_pkg::PH_HUNT;
				if (rx_byte == cmd_mark_q || rx_byte == img_mark_q) begin
					is_cmd_d = (rx_byte == cmd_mark_q);
					xor_d    = rx_byte;
					cnt_d    = '0;
					phase_d  = xcfp_pkg::PH_CMD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xcfp_pkg::PH_HUNT;
			is_cmd_q <= 1'b0;
			cnt_q    <= '0;
			alen_q   <= '0;
			dlen_q   <= '0;
			aacc_q   <= '0;
			dacc_q   <= '0;
			xor_q    <= '0;
		end else if (rx_accept) begin
			phase_q  <= phase_d;
			is_cmd_q <= is_cmd_d;
			cnt_q    <= cnt_d;
			alen_q   <= alen_d;
			dlen_q   <= dlen_d;
			aacc_q   <= aacc_d;
			dacc_q   <= dacc_d;
			xor_q    <= xor_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sum_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_fire) begin
			status_q   <= status_d;
			alen_out_q <= alen_out_d;
			aword_q    <= aword_d;
			dlen_out_q <= dlen_out_d;
			dword_q    <= dword_d;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign address_length = alen_out_q;
	assign address_word   = aword_q;
	assign payload_length = dlen_out_q;
	assign payload_word   = dword_q;

	`XCFP_ASSERT_NOW(a_res_from_sum, $rose(res_valid_q), $past(sum_fire), "result without checksum byte")
	`XCFP_ASSERT_NEXT(a_sum_to_hunt, sum_fire, phase_q == xcfp_pkg::PH_HUNT, "no return to hunt")
	`XCFP_ASSERT_NOW(a_hunt_cnt_zero, phase_q == xcfp_pkg::PH_HUNT, cnt_q == '0, "counter not cleared")
	`XCFP_ASSERT_NOW(a_non_cmd_zero, res_valid_q && status_q != xcfp_pkg::ST_CMD_OK, (alen_out_q == '0) && (aword_q == '0) && (dlen_out_q == '0) && (dword_q == '0), "fields not zero")

endmodule
